@@ sv/gbn_pkg.sv @@
`timescale 1ns / 1ps
package gbn_pkg;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_POLL = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  // raw mode codes on the input channel
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_ACK  = 2'd1;
  localparam logic [1:0] MODE_POLL = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W = 1;
  localparam int          CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT  = 1'b1;

  localparam logic [15:0] TOTAL_RST = 16'd0;
  localparam logic [7:0]  WAIT_RST  = 8'd10;

  localparam int SEQ_OUT_W = 5;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    cmd_e       kind;
    logic       ack_ok;     // ack code names a ring slot
    logic [7:0] ack_code;
    logic [7:0] ack_count;
  } cmd_t;

endpackage

@@ sv/gbn_if.sv @@
`timescale 1ns / 1ps
interface gbn_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] ack_code;
  logic [7:0] ack_count;

  modport source (output valid, mode, ack_code, ack_count, input ready);
  modport sink   (input valid, mode, ack_code, ack_count, output ready);
endinterface

interface gbn_out_if;
  logic               valid;
  logic               ready;
  logic               send_valid;
  logic [4:0]         send_seq;
  logic               rewound;
  logic signed [15:0] sent_total;
  logic               done_res;

  modport source (output valid, send_valid, send_seq, rewound, sent_total, done_res,
                  input ready);
  modport sink   (input valid, send_valid, send_seq, rewound, sent_total, done_res,
                  output ready);
endinterface

@@ sv/gbn_front.sv @@
`timescale 1ns / 1ps
module gbn_front
  import gbn_pkg::*;
#(
  parameter int SEQ_COUNT = 20
) (
  gbn_in_if.sink in_i,
  output logic   push_valid_o,
  output cmd_t   push_cmd_o,
  input  logic   push_ready_i
);

  localparam logic [7:0] SeqMax = 8'(SEQ_COUNT);

  always_comb begin
    push_cmd_o.ack_code  = in_i.ack_code;
    push_cmd_o.ack_count = in_i.ack_count;
    push_cmd_o.ack_ok    = (in_i.ack_code != 8'd0) && (in_i.ack_code <= SeqMax);
    unique case (in_i.mode)
      MODE_SEND: push_cmd_o.kind = CMD_SEND;
      MODE_ACK:  push_cmd_o.kind = CMD_ACK;
      MODE_POLL: push_cmd_o.kind = CMD_POLL;
      default:   push_cmd_o.kind = CMD_NOP;
    endcase
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

@@ sv/gbn_queue.sv @@
`timescale 1ns / 1ps
module gbn_queue
  import gbn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_cmd_i;
  end

endmodule

@@ sv/gbn_back.sv @@
`timescale 1ns / 1ps
module gbn_back
  import gbn_pkg::*;
#(
  parameter int SEQ_COUNT = 20,
  parameter int WINDOW    = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_ready_o,
  gbn_out_if.source             out_o
);

  localparam int SeqW = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
  localparam logic [SeqW:0] SeqCnt = (SeqW+1)'(SEQ_COUNT);
  localparam logic [8:0]    WinV   = 9'(WINDOW);

  logic [SEQ_COUNT-1:0] free_q, free_d;
  logic [SeqW-1:0]      next_q, next_d, base_q, base_d;
  logic signed [15:0]   sent_q, sent_d;
  logic [7:0]           idle_q, idle_d;
  logic                 fin_q, fin_d;
  logic [15:0]          total_q;
  logic [7:0]           wait_q;

  logic                 ovld_q;
  logic                 o_send_q, o_rew_q, o_done_q;
  logic [SEQ_OUT_W-1:0] o_seq_q;
  logic signed [15:0]   o_sent_q;

  logic                 take;
  logic                 send_ok, rew;
  logic [SEQ_OUT_W-1:0] seq_res;
  logic [SeqW:0]        next_x, base_x, span, idx_x;
  logic [SeqW-1:0]      idx;
  logic [8:0]           idle_inc;
  logic signed [16:0]   dec;
  logic [SEQ_COUNT-1:0] ack_mask, rw_mask;

  assign cmd_ready_o = !ovld_q || out_o.ready;
  assign take        = cmd_valid_i && cmd_ready_o;

  assign next_x   = {1'b0, next_q};
  assign base_x   = {1'b0, base_q};
  assign span     = (next_x >= base_x) ? (next_x - base_x) : (next_x + SeqCnt - base_x);
  assign idx      = SeqW'(cmd_i.ack_code - 8'd1);
  assign idx_x    = {1'b0, idx};
  assign idle_inc = {1'b0, idle_q} + 9'd1;
  assign dec      = {sent_q[15], sent_q} - $signed(17'(WINDOW));

  // per-slot masks: cumulative ack range and rewind window, both with wrap
  always_comb begin
    logic [SeqW:0] iv, di;
    for (int i = 0; i < SEQ_COUNT; i++) begin
      iv = (SeqW+1)'(i);
      di = (iv >= base_x) ? (iv - base_x) : (iv + SeqCnt - base_x);
      if (base_x <= idx_x) ack_mask[i] = (iv >= base_x) && (iv <= idx_x);
      else                 ack_mask[i] = (iv >= base_x) || (iv <= idx_x);
      rw_mask[i] = (9'(di) < WinV);
    end
  end

  always_comb begin
    free_d  = free_q;
    next_d  = next_q;
    base_d  = base_q;
    sent_d  = sent_q;
    idle_d  = idle_q;
    fin_d   = fin_q;
    send_ok = 1'b0;
    rew     = 1'b0;
    seq_res = '0;
    if (!fin_q) begin
      unique case (cmd_i.kind)
        CMD_SEND: begin
          if ((9'(span) < WinV) && free_q[next_q] && (16'(next_q) < total_q)) begin
            send_ok        = 1'b1;
            seq_res        = SEQ_OUT_W'(next_x + 1'b1);
            free_d[next_q] = 1'b0;
            next_d         = (next_x == SeqCnt - 1'b1) ? '0 : next_q + 1'b1;
            if (sent_q != 16'sh7fff) sent_d = sent_q + 16'sd1;
          end
        end
        CMD_ACK: begin
          if (cmd_i.ack_ok) begin
            free_d = free_q | ack_mask;
            base_d = (idx_x == SeqCnt - 1'b1) ? '0 : idx + 1'b1;
          end
          idle_d = '0;
          if (16'(cmd_i.ack_count) >= total_q) fin_d = 1'b1;
        end
        CMD_POLL: begin
          if (idle_inc > {1'b0, wait_q}) begin
            rew    = 1'b1;
            free_d = free_q | rw_mask;
            // clamp at the most negative value
            sent_d = (dec[16:15] == 2'b10) ? 16'sh8000 : dec[15:0];
            next_d = base_q;
            idle_d = '0;
          end else begin
            idle_d = idle_inc[7:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= '1;
      next_q  <= '0;
      base_q  <= '0;
      sent_q  <= '0;
      idle_q  <= '0;
      fin_q   <= 1'b0;
      total_q <= TOTAL_RST;
      wait_q  <= WAIT_RST;
      ovld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TOTAL: total_q <= cfg_data_i;
          CFG_WAIT:  wait_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (take) begin
        free_q <= free_d;
        next_q <= next_d;
        base_q <= base_d;
        sent_q <= sent_d;
        idle_q <= idle_d;
        fin_q  <= fin_d;
      end
      if (take)             ovld_q <= 1'b1;
      else if (out_o.ready) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      o_send_q <= send_ok;
      o_seq_q  <= seq_res;
      o_rew_q  <= rew;
      o_sent_q <= sent_d;
      o_done_q <= fin_d;
    end
  end

  assign out_o.valid      = ovld_q;
  assign out_o.send_valid = o_send_q;
  assign out_o.send_seq   = o_seq_q;
  assign out_o.rewound    = o_rew_q;
  assign out_o.sent_total = o_sent_q;
  assign out_o.done_res   = o_done_q;

endmodule

@@ sv/go_back_n_sender_window.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Payload                                          Handshake
// in_i      in   mode, ack_code, ack_count                        valid/ready
// out_o     out  send_valid, send_seq, rewound, sent_total,       valid/ready
//                done_res
// cfg       in   cfg_idx_i, cfg_data_i                            cfg_we_i
//
// One beat in, one beat out, one beat per cycle sustained while out_o is ready:
// the front writes the decoded beat into a 2-entry queue, and from there the back
// updates the window state and the output register together.
// Reset clears the window (all slots free) and loads register defaults; no
// clearing pass. Either side may stall on its own; the queue absorbs it.
module go_back_n_sender_window
  import gbn_pkg::*;
#(
  parameter int SEQ_COUNT = 20,
  parameter int WINDOW    = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gbn_in_if.sink                in_i,
  gbn_out_if.source             out_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  gbn_front #(
    .SEQ_COUNT(SEQ_COUNT)
  ) u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  gbn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  gbn_back #(
    .SEQ_COUNT(SEQ_COUNT),
    .WINDOW   (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
